@@ hdl/stfp_pkg.sv @@
`timescale 1ns / 1ps

package stfp_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [31:0] DEC_BASE = 32'd10;

    localparam int unsigned OFFSET_W = 16;
    localparam int unsigned ACC_W    = 32;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    typedef enum logic [2:0] {
        PH_SEEK,
        PH_START,
        PH_NUM,
        PH_DONE,
        PH_FAILED
    } phase_t;

    typedef struct packed {
        logic                       status;
        logic                       target_valid;
        logic signed [OFFSET_W-1:0] x_offset;
        logic signed [OFFSET_W-1:0] y_offset;
    } result_t;

endpackage

@@ hdl/stfp_core.sv @@
`timescale 1ns / 1ps

module stfp_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  logic [7:0]       byte_value,
    input  logic             chunk_end,
    output logic             res_valid,
    output stfp_pkg::result_t res
);
    import stfp_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [1:0]          field_reg, field_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic                neg_reg, neg_next;
    logic                seen_reg, seen_next;
    logic                hvalid_reg, hvalid_next;
    logic [OFFSET_W-1:0] hx_reg, hx_next;

    logic                is_digit;
    logic [ACC_W-1:0]    digit_ext;
    logic [ACC_W-1:0]    acc_times_ten;
    logic [OFFSET_W-1:0] cur_low;
    logic [OFFSET_W-1:0] upd_low;
    logic                emit_ok;
    logic                emit_err;

    assign is_digit      = (byte_value >= CH_ZERO) && (byte_value <= CH_NINE);
    assign digit_ext     = {{(ACC_W-4){1'b0}}, 4'(byte_value - CH_ZERO)};
    assign acc_times_ten = acc_reg * DEC_BASE;
    assign cur_low       = neg_reg ? (~acc_reg[OFFSET_W-1:0] + 1'b1) : acc_reg[OFFSET_W-1:0];
    assign upd_low       = neg_next ? (~acc_next[OFFSET_W-1:0] + 1'b1)
                                    : acc_next[OFFSET_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SEEK;
            field_reg  <= 2'd0;
            acc_reg    <= '0;
            neg_reg    <= 1'b0;
            seen_reg   <= 1'b0;
            hvalid_reg <= 1'b0;
            hx_reg     <= '0;
        end else if (step) begin
            phase_reg  <= chunk_end ? PH_SEEK : phase_next;
            field_reg  <= chunk_end ? 2'd0 : field_next;
            acc_reg    <= chunk_end ? '0 : acc_next;
            neg_reg    <= chunk_end ? 1'b0 : neg_next;
            seen_reg   <= chunk_end ? 1'b0 : seen_next;
            hvalid_reg <= chunk_end ? 1'b0 : hvalid_next;
            hx_reg     <= chunk_end ? '0 : hx_next;
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        field_next  = field_reg;
        acc_next    = acc_reg;
        neg_next    = neg_reg;
        seen_next   = seen_reg;
        hvalid_next = hvalid_reg;
        hx_next     = hx_reg;
        emit_ok     = 1'b0;
        unique case (phase_reg)
            PH_SEEK: begin
                if (byte_value == CH_DOLLAR) begin
                    phase_next = PH_START;
                    field_next = 2'd0;
                    acc_next   = '0;
                    neg_next   = 1'b0;
                    seen_next  = 1'b0;
                end
            end
            PH_START, PH_NUM: begin
                priority if (phase_reg == PH_START &&
                             (byte_value == CH_PLUS || byte_value == CH_MINUS)) begin
                    neg_next   = (byte_value == CH_MINUS);
                    phase_next = PH_NUM;
                end else if (is_digit) begin
                    acc_next   = acc_times_ten + digit_ext;
                    seen_next  = 1'b1;
                    phase_next = PH_NUM;
                end else if (!seen_reg) begin
                    phase_next = PH_FAILED;
                end else if (field_reg >= 2'd2) begin
                    emit_ok    = 1'b1;
                    phase_next = PH_DONE;
                end else if (byte_value == CH_COMMA) begin
                    if (field_reg == 2'd0) begin
                        hvalid_next = (acc_reg != '0);
                    end else begin
                        hx_next = cur_low;
                    end
                    field_next = field_reg + 2'd1;
                    acc_next   = '0;
                    neg_next   = 1'b0;
                    seen_next  = 1'b0;
                    phase_next = PH_START;
                end else begin
                    phase_next = PH_FAILED;
                end
            end
            PH_DONE, PH_FAILED: begin
            end
            default: begin
            end
        endcase
    end

    // chunk end closes any frame that has not already produced its word
    always_comb begin
        emit_err = 1'b0;
        if (chunk_end && !emit_ok && phase_next != PH_DONE) begin
            if (phase_next == PH_NUM && field_next >= 2'd2 && seen_next) begin
                emit_err = 1'b0;
            end else begin
                emit_err = 1'b1;
            end
        end
    end

    assign res_valid = step && (emit_ok || (chunk_end && phase_next != PH_DONE));

    always_comb begin
        if (emit_err) begin
            res.status       = STATUS_ERROR;
            res.target_valid = 1'b0;
            res.x_offset     = '0;
            res.y_offset     = '0;
        end else begin
            res.status       = STATUS_OK;
            res.target_valid = hvalid_next;
            res.x_offset     = hx_next;
            res.y_offset     = upd_low;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (step && chunk_end) |=> (phase_reg == PH_SEEK && field_reg == 2'd0 && !seen_reg))
        else $error("parser not back in seek after chunk end");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (step && chunk_end && phase_reg != PH_DONE) |-> res_valid)
        else $error("chunk end without a result word");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DONE || phase_reg == PH_FAILED || phase_reg == PH_SEEK) && !chunk_end
        |-> !res_valid)
        else $error("result word outside an open frame");

endmodule

@@ hdl/stfp_out_fifo.sv @@
`timescale 1ns / 1ps

module stfp_out_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  stfp_pkg::result_t push_data,
    output logic              space,
    output logic              m_valid,
    input  logic              m_ready,
    output stfp_pkg::result_t head
);
    import stfp_pkg::*;

    result_t    mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != 2'd0);
    // space does not look at m_ready, so no path runs from m_ready to s_ready
    assign space   = (count_reg != 2'd2);
    assign head    = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg != 2'd2))
        else $error("push into full result buffer");

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("result buffer count out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop && count_reg != 2'd2) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("result buffer count lost a push");

endmodule

@@ hdl/signed_triple_frame_parser.sv @@
`timescale 1ns / 1ps

// signed triple frame parser
// input channel s_*: one received byte per word, s_chunk_end marks the last
// byte of a chunk. each chunk gives exactly one result word on m_*: status
// ok with target_valid and the low 16 bits of the second and third numbers
// of a "$a,b,c" frame, or status error when the chunk ends without one.
// result path: the byte that completes the frame is taken into the input
// register, then the parser step writes the word into the two-entry result
// buffer, which raises m_valid.
// throughput: one byte per cycle while the result buffer has space; the
// parser step is a constant multiply by ten and add on the 32-bit accumulator.
// when the receiver stalls, the result buffer absorbs up to two words; with
// both entries full, s_ready drops once the input register holds a byte.
// s_ready does not depend on m_ready.
// reset (aresetn low, synchronous) empties both registers and the buffer and
// returns the parser to searching for the start marker.
module signed_triple_frame_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_byte_value,
    input  logic        s_chunk_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_status,
    output logic        m_target_valid,
    output logic signed [15:0] m_x_offset,
    output logic signed [15:0] m_y_offset
);
    import stfp_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       space;
    logic       step;
    logic       res_valid;
    result_t    res;
    result_t    head;

    assign step    = in_valid_reg && space;
    assign s_ready = !in_valid_reg || space;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_byte_value;
            in_last_reg <= s_chunk_end;
        end
    end

    stfp_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .byte_value (in_byte_reg),
        .chunk_end  (in_last_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    stfp_out_fifo u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_data (res),
        .space     (space),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .head      (head)
    );

    assign m_status       = head.status;
    assign m_target_valid = head.target_valid;
    assign m_x_offset     = head.x_offset;
    assign m_y_offset     = head.y_offset;

endmodule
